// ===== hdl/gwf_pkg.sv =====
// Package for the grid water flow step unit: grid sizes, codes, helpers.
// No dependencies.
`default_nettype none
package gwf_pkg;
    localparam int MaxWidth   = 32;
    localparam int MaxDepth   = 32;
    localparam int Corners    = (MaxWidth + 1) * (MaxDepth + 1);
    localparam int Cells      = MaxWidth * MaxDepth;
    localparam int CornerAw   = $clog2(Corners);
    localparam int CellAw     = $clog2(Cells);

    localparam logic [1:0] CMD_WR_CORNER = 2'd0;
    localparam logic [1:0] CMD_WR_WATER  = 2'd1;
    localparam logic [1:0] CMD_RUN       = 2'd2;
    localparam logic [1:0] CMD_RD_WATER  = 2'd3;

    localparam logic [2:0] REG_WIDTH    = 3'd0;
    localparam logic [2:0] REG_DEPTH    = 3'd1;
    localparam logic [2:0] REG_CAPACITY = 3'd2;
    localparam logic [2:0] REG_RATE     = 3'd3;
    localparam logic [2:0] REG_MIN_FLOW = 3'd4;

    // request to the shared divider
    typedef struct packed {
        logic        go;
        logic [63:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/grid_water_flow_step_unit.sv =====
// Grid water flow step unit: top level with stores, sequencer and config.
// Depends on gwf_pkg and gwf_div.
// Loads and reads strobe done as the sequencer returns to idle; the next
// command can be taken in that same cycle. A run walks the grid in four
// sweeps (surface, requests, transfers, write back); the surface and
// transfer sweeps share a serial divider, and a transfer uses it only when
// the flow is scaled. One command at a time; busy is high while working.
// Reset returns the sequencer to idle and sets the config to its defaults;
// stores hold no reset value.
`default_nettype none
module grid_water_flow_step_unit
    import gwf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         command,
    input  wire logic [10:0]        index,
    input  wire logic signed [31:0] value,
    output logic                    done,
    output logic [31:0]             read_value,
    output logic                    status
);
    // configuration
    logic [5:0]  width_reg, depth_reg;
    logic [31:0] cap_reg, minf_reg;
    logic [16:0] rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 6'd32;
            depth_reg <= 6'd32;
            cap_reg   <= 32'd255232;
            rate_reg  <= 17'd16384;
            minf_reg  <= 32'd26;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:    width_reg <= cfg_data[5:0];
                REG_DEPTH:    depth_reg <= cfg_data[5:0];
                REG_CAPACITY: cap_reg   <= cfg_data;
                REG_RATE:     rate_reg  <= cfg_data[16:0];
                REG_MIN_FLOW: minf_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // effective geometry
    logic [5:0]  w, dp;
    logic [31:0] cap;
    logic [16:0] fr;
    assign w   = (width_reg == 6'd0) ? 6'd1 :
                 (width_reg > 6'(MaxWidth)) ? 6'(MaxWidth) : width_reg;
    assign dp  = (depth_reg == 6'd0) ? 6'd1 :
                 (depth_reg > 6'(MaxDepth)) ? 6'(MaxDepth) : depth_reg;
    assign cap = (cap_reg == 32'd0) ? 32'd1 : cap_reg;
    assign fr  = (rate_reg > 17'd65536) ? 17'd65536 : rate_reg;

    logic [11:0] n_cells, n_corners;
    assign n_cells   = 12'(w * dp);
    assign n_corners = 12'((w + 6'd1) * (dp + 6'd1));

    // memories: single read port each, registered read
    logic [31:0] corner_mem [Corners];
    logic [31:0] water_mem  [Cells];
    logic [31:0] surf_mem   [Cells];
    logic [31:0] req_mem    [Cells];
    logic [33:0] next_mem   [Cells];

    logic [CornerAw-1:0] c_raddr, c_waddr;
    logic [CellAw-1:0]   w_raddr, w_waddr, s_raddr, s_waddr;
    logic [CellAw-1:0]   r_raddr, r_waddr, n_raddr, n_waddr;
    logic                c_we, w_we, s_we, r_we, n_we;
    logic [31:0]         c_wd, w_wd, s_wd, r_wd;
    logic [33:0]         n_wd;
    logic [31:0]         c_rd, w_rd, s_rd, r_rd;
    logic [33:0]         n_rd;

    always_ff @(posedge clk)
    begin
        if (c_we) corner_mem[c_waddr] <= c_wd;
        c_rd <= corner_mem[c_raddr];
        if (w_we) water_mem[w_waddr] <= w_wd;
        w_rd <= water_mem[w_raddr];
        if (s_we) surf_mem[s_waddr] <= s_wd;
        s_rd <= surf_mem[s_raddr];
        if (r_we) req_mem[r_waddr] <= r_wd;
        r_rd <= req_mem[r_raddr];
        if (n_we) next_mem[n_waddr] <= n_wd;
        n_rd <= next_mem[n_raddr];
    end

    // sequencer
    typedef enum logic [17:0] {
        S_IDLE  = 18'b000000000000000001,
        S_RDW   = 18'b000000000000000010,
        S_RESP  = 18'b000000000000000100,
        S_SC    = 18'b000000000000001000, // surface: read corners/water
        S_SCW   = 18'b000000000000010000,
        S_SDIV  = 18'b000000000000100000,
        S_PRD   = 18'b000000000001000000, // pair: read surfaces
        S_PRD2  = 18'b000000000010000000,
        S_PMUL  = 18'b000000000100000000,
        S_PMUL2 = 18'b000000001000000000,
        S_PFLOW = 18'b000000010000000000,
        S_PSRC  = 18'b000000100000000000, // read src req / water / next
        S_PSRCW = 18'b000001000000000000,
        S_PDIV  = 18'b000010000000000000,
        S_PDST  = 18'b000100000000000000,
        S_PDSTW = 18'b001000000000000000,
        S_WB    = 18'b010000000000000000,
        S_WBW   = 18'b100000000000000000
    } state_t;

    state_t state_reg;
    logic [1:0]  cmd_reg;
    logic [10:0] idx_reg;
    logic [31:0] val_reg;
    logic        st_reg;
    logic        pass_reg;      // 0 request pass, 1 transfer pass
    logic        dir_reg;       // 0 right, 1 down
    logic [5:0]  x_reg, z_reg;
    logic [1:0]  k_reg;         // corner sub-read
    logic [CellAw-1:0]   a_reg, b_reg, src_reg, dst_reg;
    logic [33:0] csum_reg;
    logic signed [31:0] sa_reg, sb_reg;
    logic [31:0] diff_reg, flow_reg, wat_reg;
    logic [63:0] p_reg;
    logic [48:0] hi_reg, lo_reg;
    logic [33:0] nv_reg;
    logic        done_reg;
    logic [31:0] rv_reg;
    div_req_t    dreq;
    div_rsp_t    drsp;

    gwf_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // derived indices
    logic [CellAw-1:0]   cell_i;
    logic [CornerAw-1:0] corner_base, corner_k;
    assign cell_i      = CellAw'(z_reg * w + x_reg);
    assign corner_base = CornerAw'(z_reg * (w + 6'd1) + x_reg);
    always_comb
    begin
        case (k_reg)
            2'd0:    corner_k = corner_base;
            2'd1:    corner_k = corner_base + CornerAw'(1);
            2'd2:    corner_k = corner_base + CornerAw'(w + 6'd1);
            default: corner_k = corner_base + CornerAw'(w + 6'd2);
        endcase
    end

    logic last_x, last_z;
    assign last_x = (x_reg == w - 6'd1);
    assign last_z = (z_reg == dp - 6'd1);

    // surface from corner sum and depth
    logic signed [34:0] mean_s, surf_s;
    assign mean_s = 35'(signed'(csum_reg) >>> 2);
    assign surf_s = mean_s + signed'({3'b0, drsp.quo[31:0]});

    // pair flow after multiply stages
    logic [49:0] f_full;
    assign f_full = 50'((hi_reg + 49'(lo_reg[48:32])) >> 1);
    logic [31:0] f_sat;
    assign f_sat = (f_full > 50'hFFFFFFFF) ? 32'hFFFFFFFF : f_full[31:0];

    // saturating 34-bit add of a signed delta
    function automatic logic [33:0] sat34(input logic [33:0] a,
                                          input logic signed [33:0] d);
        logic signed [34:0] s;
        begin
            s = signed'({a[33], a}) + signed'({d[33], d});
            if (s > 35'sh1_FFFFFFFF)       sat34 = 34'h1_FFFFFFFF;
            else if (s < -35'sh2_00000000) sat34 = 34'h2_00000000;
            else                           sat34 = s[33:0];
        end
    endfunction

    always_comb
    begin
        c_raddr = corner_k;
        c_waddr = idx_reg[CornerAw-1:0];
        c_we = 1'b0; c_wd = val_reg;
        w_raddr = (state_reg == S_IDLE || state_reg == S_RDW) ?
                  idx_reg[CellAw-1:0] : cell_i;
        w_waddr = idx_reg[CellAw-1:0];
        w_we = 1'b0; w_wd = val_reg;
        s_raddr = a_reg; s_waddr = cell_i; s_we = 1'b0; s_wd = surf_s[31:0];
        r_raddr = src_reg; r_waddr = src_reg; r_we = 1'b0; r_wd = '0;
        n_raddr = src_reg; n_waddr = src_reg; n_we = 1'b0; n_wd = '0;
        dreq.go = 1'b0; dreq.num = '0; dreq.den = cap;
        if (state_reg == S_IDLE && start && !busy)
        begin
            w_raddr = index[CellAw-1:0];
        end
        case (state_reg)
            S_RDW:
            begin
                if (cmd_reg == CMD_WR_CORNER && !st_reg) c_we = 1'b1;
                if (cmd_reg == CMD_WR_WATER && !st_reg)
                begin
                    w_we = 1'b1;
                    w_wd = val_reg[31] ? 32'd0 : val_reg;
                end
            end
            S_SDIV:
            begin
                if (drsp.done)
                begin
                    s_we = 1'b1;
                    // a depth of 2^32 or more always tops the signed range
                    if (surf_s > 35'sh7FFFFFFF || drsp.quo[63:32] != 32'd0)
                        s_wd = 32'h7FFFFFFF;
                    r_we = 1'b1; r_waddr = cell_i; r_wd = '0;
                    n_we = 1'b1; n_waddr = cell_i; n_wd = {2'b0, wat_reg};
                end
            end
            S_SCW:
            begin
                if (k_reg == 2'd3)
                begin
                    dreq.go  = 1'b1;
                    dreq.num = {16'd0, w_rd, 16'd0};
                end
            end
            S_PRD:   s_raddr = cell_i;
            S_PRD2:  s_raddr = b_reg;
            S_PSRC:  begin r_raddr = src_reg; w_raddr = src_reg; n_raddr = src_reg; end
            S_PSRCW:
            begin
                if (!pass_reg)
                begin
                    r_we = 1'b1;
                    r_wd = (33'(r_rd) + 33'(flow_reg) > 33'hFFFFFFFF) ?
                           32'hFFFFFFFF : r_rd + flow_reg;
                end
                else if (r_rd > w_rd)
                begin
                    dreq.go  = 1'b1;
                    dreq.num = 64'(flow_reg) * 64'(w_rd);
                    dreq.den = r_rd;
                end
            end
            S_PDIV:
            begin
                // write the source once the final amount is known
                if (k_reg == 2'd3 || drsp.done)
                begin
                    n_we = 1'b1;
                    n_wd = sat34(nv_reg, -signed'(34'(drsp.done ? drsp.quo[31:0] :
                                                       flow_reg)));
                end
            end
            S_PDST:  n_raddr = dst_reg;
            S_PDSTW:
            begin
                n_we = 1'b1; n_waddr = dst_reg;
                n_wd = sat34(n_rd, signed'(34'(flow_reg)));
            end
            S_WB:    n_raddr = cell_i;
            S_WBW:
            begin
                w_we = 1'b1; w_waddr = cell_i;
                w_wd = n_rd[33] ? 32'd0 : n_rd[32] ? 32'hFFFFFFFF : n_rd[31:0];
            end
            default: ;
        endcase
    end

    // address of neighbor
    logic [CellAw-1:0] nb;
    assign nb = dir_reg ? cell_i + CellAw'(w) : cell_i + CellAw'(1);
    logic has_pair;
    assign has_pair = dir_reg ? !last_z : !last_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        cmd_reg <= command;
                        idx_reg <= index;
                        val_reg <= value;
                        x_reg <= '0; z_reg <= '0; k_reg <= '0;
                        dir_reg <= 1'b0; pass_reg <= 1'b0;
                        csum_reg <= '0;
                        st_reg <= (command == CMD_WR_CORNER) ? (12'(index) >= n_corners) :
                                  (command == CMD_RUN) ? 1'b0 : (12'(index) >= n_cells);
                        state_reg <= (command == CMD_RUN) ? S_SC : S_RDW;
                    end
                S_RDW:
                    state_reg <= S_RESP;
                S_RESP:
                begin
                    done_reg <= 1'b1;
                    rv_reg <= (cmd_reg == CMD_RD_WATER && !st_reg) ? w_rd : 32'd0;
                    state_reg <= S_IDLE;
                end
                S_SC:
                    state_reg <= S_SCW;
                S_SCW:
                begin
                    csum_reg <= csum_reg + {{2{c_rd[31]}}, c_rd};
                    if (k_reg == 2'd3)
                    begin
                        wat_reg <= w_rd;
                        state_reg <= S_SDIV;
                    end
                    else
                    begin
                        state_reg <= S_SC;
                    end
                    k_reg <= k_reg + 2'd1;
                end
                S_SDIV:
                    if (drsp.done)
                    begin
                        csum_reg <= '0;
                        if (last_x)
                        begin
                            x_reg <= '0;
                            if (last_z) begin z_reg <= '0; state_reg <= S_PRD; end
                            else z_reg <= z_reg + 6'd1;
                        end
                        else x_reg <= x_reg + 6'd1;
                        if (!(last_x && last_z)) state_reg <= S_SC;
                    end
                S_PRD:
                begin
                    if (has_pair)
                    begin
                        a_reg <= cell_i; b_reg <= nb;
                        state_reg <= S_PRD2;
                    end
                    else
                    begin
                        // advance pair position
                        if (dir_reg == 1'b0) dir_reg <= 1'b1;
                        else
                        begin
                            dir_reg <= 1'b0;
                            if (last_x)
                            begin
                                x_reg <= '0;
                                if (last_z)
                                begin
                                    z_reg <= '0;
                                    if (pass_reg) state_reg <= S_WB;
                                    pass_reg <= 1'b1;
                                end
                                else z_reg <= z_reg + 6'd1;
                            end
                            else x_reg <= x_reg + 6'd1;
                        end
                    end
                end
                S_PRD2:
                begin
                    sa_reg <= s_rd;
                    state_reg <= S_PMUL;
                end
                S_PMUL:
                begin
                    sb_reg <= s_rd;
                    state_reg <= S_PMUL2;
                end
                S_PMUL2:
                begin
                    if (sa_reg == sb_reg)
                    begin
                        state_reg <= S_PFLOW;
                        flow_reg <= '0;
                        diff_reg <= '0;
                    end
                    else
                    begin
                        if (sa_reg > sb_reg)
                        begin
                            src_reg <= a_reg; dst_reg <= b_reg;
                            diff_reg <= 32'(33'(signed'({sa_reg[31], sa_reg}) -
                                           signed'({sb_reg[31], sb_reg})));
                        end
                        else
                        begin
                            src_reg <= b_reg; dst_reg <= a_reg;
                            diff_reg <= 32'(33'(signed'({sb_reg[31], sb_reg}) -
                                           signed'({sa_reg[31], sa_reg})));
                        end
                        state_reg <= S_PFLOW;
                    end
                    p_reg <= '0;
                end
                S_PFLOW:
                begin
                    // two registered multiply steps folded via k_reg
                    if (k_reg == 2'd0)
                    begin
                        p_reg <= 64'(diff_reg) * 64'(cap);
                        k_reg <= 2'd1;
                    end
                    else if (k_reg == 2'd1)
                    begin
                        hi_reg <= 49'(p_reg[63:32]) * 49'(fr);
                        lo_reg <= 49'(p_reg[31:0]) * 49'(fr);
                        k_reg <= 2'd2;
                    end
                    else
                    begin
                        k_reg <= 2'd0;
                        flow_reg <= f_sat;
                        if (diff_reg == 32'd0 || f_sat < minf_reg)
                            state_reg <= S_PRD;
                        else
                            state_reg <= S_PSRC;
                        if (diff_reg == 32'd0 || f_sat < minf_reg)
                        begin
                            if (dir_reg == 1'b0) dir_reg <= 1'b1;
                            else
                            begin
                                dir_reg <= 1'b0;
                                if (last_x)
                                begin
                                    x_reg <= '0;
                                    if (last_z)
                                    begin
                                        z_reg <= '0;
                                        if (pass_reg) state_reg <= S_WB;
                                        pass_reg <= 1'b1;
                                    end
                                    else z_reg <= z_reg + 6'd1;
                                end
                                else x_reg <= x_reg + 6'd1;
                            end
                        end
                    end
                end
                S_PSRC:
                    state_reg <= S_PSRCW;
                S_PSRCW:
                begin
                    nv_reg <= n_rd;
                    if (!pass_reg)
                    begin
                        state_reg <= S_PRD;
                        if (dir_reg == 1'b0) dir_reg <= 1'b1;
                        else
                        begin
                            dir_reg <= 1'b0;
                            if (last_x)
                            begin
                                x_reg <= '0;
                                if (last_z) begin z_reg <= '0; pass_reg <= 1'b1; end
                                else z_reg <= z_reg + 6'd1;
                            end
                            else x_reg <= x_reg + 6'd1;
                        end
                    end
                    else if (r_rd > w_rd)
                        state_reg <= S_PDIV;
                    else
                    begin
                        state_reg <= S_PDIV;
                        k_reg <= 2'd3; // no scaling needed
                    end
                end
                S_PDIV:
                begin
                    if (k_reg == 2'd3 || drsp.done)
                    begin
                        // flow_reg holds final amount from here on
                        state_reg <= S_PDST;
                        k_reg <= 2'd0;
                    end
                    if (drsp.done) flow_reg <= drsp.quo[31:0];
                end
                S_PDST:
                    state_reg <= S_PDSTW;
                S_PDSTW:
                begin
                    state_reg <= S_PRD;
                    if (dir_reg == 1'b0) dir_reg <= 1'b1;
                    else
                    begin
                        dir_reg <= 1'b0;
                        if (last_x)
                        begin
                            x_reg <= '0;
                            if (last_z) begin z_reg <= '0; state_reg <= S_WB; end
                            else z_reg <= z_reg + 6'd1;
                        end
                        else x_reg <= x_reg + 6'd1;
                    end
                end
                S_WB:
                    state_reg <= S_WBW;
                S_WBW:
                begin
                    if (last_x)
                    begin
                        x_reg <= '0;
                        if (last_z)
                        begin
                            z_reg <= '0;
                            state_reg <= S_RESP;
                            st_reg <= 1'b0;
                        end
                        else begin z_reg <= z_reg + 6'd1; state_reg <= S_WB; end
                    end
                    else begin x_reg <= x_reg + 6'd1; state_reg <= S_WB; end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign read_value = rv_reg;
    assign status     = st_reg & done_reg;
endmodule
`default_nettype wire

// ===== hdl/gwf_div.sv =====
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// Depends on gwf_pkg.
`default_nettype none
module gwf_div
    import gwf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic [63:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted = {rem_reg[31:0], quo_reg[63]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule
`default_nettype wire
